@@ design/ett_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ett_pkg: shared widths, token and error codes, lexer modes and result types
// for the text tokenizer. No dependencies.
package ett_pkg;

    // Internal counter widths
    localparam int POSITION_WIDTH = 24;
    localparam int LINE_WIDTH     = 20;

    // Port field widths
    localparam int KIND_W       = 4;
    localparam int CODE_W       = 3;
    localparam int FIELD_W      = 24;
    localparam int LINE_FIELD_W = 20;

    localparam int POS_EXT_W  = (POSITION_WIDTH > FIELD_W) ? POSITION_WIDTH : FIELD_W;
    localparam int LINE_EXT_W = (LINE_WIDTH > LINE_FIELD_W) ? LINE_WIDTH : LINE_FIELD_W;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_END      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_TERMINAL = 4'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_COMMENT  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_STRING   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 4'd9;

    // Error codes
    localparam logic [CODE_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [CODE_W-1:0] ERR_CR_NO_LF    = 3'd1;
    localparam logic [CODE_W-1:0] ERR_SLASH       = 3'd2;
    localparam logic [CODE_W-1:0] ERR_OPEN_STRING = 3'd3;
    localparam logic [CODE_W-1:0] ERR_TWO_DOTS    = 3'd4;
    localparam logic [CODE_W-1:0] ERR_BAD_CHAR    = 3'd5;
    localparam logic [CODE_W-1:0] ERR_BAD_BRACKET = 3'd6;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_AFTER_CR,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_STRING,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_BRK_OPEN,
        MODE_BRK_DIGITS,
        MODE_HALT
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [CODE_W-1:0]       code;
        logic [FIELD_W-1:0]      start;
        logic [FIELD_W-1:0]      length;
        logic [LINE_FIELD_W-1:0] line;
        logic                    last;
    } t_token;

    // Results of one lexed byte, in order
    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_lex_out;

    function automatic logic [FIELD_W-1:0] sat_pos(input logic [POSITION_WIDTH-1:0] v);
        logic [POS_EXT_W-1:0] e;
        e = POS_EXT_W'(v);
        if (e > POS_EXT_W'({FIELD_W{1'b1}})) begin
            return '1;
        end
        return e[FIELD_W-1:0];
    endfunction

    function automatic logic [LINE_FIELD_W-1:0] sat_line(input logic [LINE_WIDTH-1:0] v);
        logic [LINE_EXT_W-1:0] e;
        e = LINE_EXT_W'(v);
        if (e > LINE_EXT_W'({LINE_FIELD_W{1'b1}})) begin
            return '1;
        end
        return e[LINE_FIELD_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ design/ett_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ett_in_if / ett_out_if: valid-ready channels for text bytes and tokens.
// Depends on ett_pkg.
interface ett_in_if;
    import ett_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       restart;

    modport source (output valid, output text_byte, output restart, input ready);
    modport sink   (input valid, input text_byte, input restart, output ready);
endinterface

interface ett_out_if;
    import ett_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       token_kind;
    logic [CODE_W-1:0]       error_code;
    logic [FIELD_W-1:0]      token_start;
    logic [FIELD_W-1:0]      token_length;
    logic [LINE_FIELD_W-1:0] line_number;
    logic                    last_of_run;

    modport source (output valid, output token_kind, output error_code,
                    output token_start, output token_length, output line_number,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input error_code,
                    input token_start, input token_length, input line_number,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

@@ design/ett_lex_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ett_lex_core: lexer state registers and the one-byte lexing step.
// Depends on ett_pkg.
module ett_lex_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_restart,
    output ett_pkg::t_lex_out     o_lex
);
    import ett_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UPR_E = 8'h45;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LWR_E = 8'h65;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    t_mode                     r_mode, eff_mode, n_mode;
    logic                      r_dot, eff_dot, n_dot;
    logic [POSITION_WIDTH-1:0] r_start, eff_start, n_start;
    logic [POSITION_WIDTH-1:0] r_pos, eff_pos, pos_inc;
    logic [LINE_WIDTH-1:0]     r_line, eff_line, n_line;

    logic                      is_digit, is_letter, is_eol;
    logic                      relex, line_inc, active;
    logic                      p_emit, s_emit;
    logic [KIND_W-1:0]         p_kind, s_kind;
    logic [CODE_W-1:0]         p_code, s_code;
    logic [POSITION_WIDTH-1:0] p_start, p_len, s_len;
    logic [7:0]                lc;
    t_token                    tok_p, tok_s;

    // Restart takes effect before the byte
    assign eff_mode  = i_restart ? MODE_IDLE : r_mode;
    assign eff_dot   = i_restart ? 1'b0 : r_dot;
    assign eff_start = i_restart ? '0 : r_start;
    assign eff_pos   = i_restart ? '0 : r_pos;
    assign eff_line  = i_restart ? LINE_WIDTH'(1) : r_line;
    assign pos_inc   = (eff_pos == '1) ? eff_pos : eff_pos + POSITION_WIDTH'(1);
    assign active    = (eff_mode != MODE_HALT);

    assign lc        = i_byte | CH_SPACE;
    assign is_letter = (lc >= 8'h61) && (lc <= 8'h7A);
    assign is_digit  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_eol    = (i_byte == CH_LF) || (i_byte == CH_CR) || (i_byte == CH_NUL);

    always_comb begin
        n_mode   = eff_mode;
        n_dot    = eff_dot;
        n_start  = eff_start;
        line_inc = 1'b0;
        relex    = 1'b0;
        p_emit   = 1'b0;
        p_kind   = KIND_ERROR;
        p_code   = ERR_NONE;
        p_start  = eff_pos;
        p_len    = '0;
        s_emit   = 1'b0;
        s_kind   = KIND_END;
        s_code   = ERR_NONE;
        s_len    = '0;

        // Finish or extend the pending token
        case (eff_mode)
            MODE_AFTER_CR: begin
                if (i_byte == CH_LF) begin
                    line_inc = 1'b1;
                    n_mode   = MODE_IDLE;
                end else begin
                    p_emit = 1'b1;
                    p_code = ERR_CR_NO_LF;
                    n_mode = MODE_HALT;
                end
            end
            MODE_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    n_mode = MODE_COMMENT;
                end else begin
                    p_emit = 1'b1;
                    p_code = ERR_SLASH;
                    n_mode = MODE_HALT;
                end
            end
            MODE_COMMENT: begin
                if (is_eol) begin
                    p_emit  = 1'b1;
                    p_kind  = KIND_COMMENT;
                    p_start = eff_start;
                    p_len   = eff_pos - eff_start;
                    n_mode  = MODE_IDLE;
                    relex   = 1'b1;
                end
            end
            MODE_STRING: begin
                if (i_byte == CH_QUOTE) begin
                    p_emit  = 1'b1;
                    p_kind  = KIND_STRING;
                    p_start = eff_start;
                    p_len   = pos_inc - eff_start;
                    n_mode  = MODE_IDLE;
                end else if (is_eol) begin
                    p_emit = 1'b1;
                    p_code = ERR_OPEN_STRING;
                    n_mode = MODE_HALT;
                end
            end
            MODE_NUMBER: begin
                if (i_byte == CH_DOT) begin
                    if (eff_dot) begin
                        p_emit = 1'b1;
                        p_code = ERR_TWO_DOTS;
                        n_mode = MODE_HALT;
                    end else begin
                        n_dot = 1'b1;
                    end
                end else if (!(is_digit || i_byte == CH_LWR_E || i_byte == CH_UPR_E ||
                               i_byte == CH_PLUS || i_byte == CH_MINUS)) begin
                    p_emit  = 1'b1;
                    p_kind  = KIND_NUMBER;
                    p_start = eff_start;
                    p_len   = eff_pos - eff_start;
                    n_mode  = MODE_IDLE;
                    relex   = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (i_byte == CH_LBRK) begin
                    n_mode = MODE_BRK_OPEN;
                end else if (!(is_letter || is_digit || i_byte == CH_UNDER)) begin
                    p_emit  = 1'b1;
                    p_kind  = KIND_IDENT;
                    p_start = eff_start;
                    p_len   = eff_pos - eff_start;
                    n_mode  = MODE_IDLE;
                    relex   = 1'b1;
                end
            end
            MODE_BRK_OPEN: begin
                if (is_digit) begin
                    n_mode = MODE_BRK_DIGITS;
                end else begin
                    p_emit = 1'b1;
                    p_code = ERR_BAD_BRACKET;
                    n_mode = MODE_HALT;
                end
            end
            MODE_BRK_DIGITS: begin
                if (i_byte == CH_RBRK) begin
                    p_emit  = 1'b1;
                    p_kind  = KIND_IDENT;
                    p_start = eff_start;
                    p_len   = pos_inc - eff_start;
                    n_mode  = MODE_IDLE;
                end else if (!is_digit) begin
                    p_emit = 1'b1;
                    p_code = ERR_BAD_BRACKET;
                    n_mode = MODE_HALT;
                end
            end
            MODE_HALT: begin
                n_mode = MODE_HALT;
            end
            default: begin
                n_mode = MODE_IDLE;
                relex  = 1'b1;
            end
        endcase

        // Lex the byte itself from the idle mode
        if (relex) begin
            case (i_byte)
                CH_CR:    n_mode = MODE_AFTER_CR;
                CH_LF:    line_inc = 1'b1;
                CH_SPACE: n_mode = MODE_IDLE;
                CH_TAB:   n_mode = MODE_IDLE;
                CH_NUL: begin
                    s_emit = 1'b1;
                    s_kind = KIND_END;
                    n_mode = MODE_HALT;
                end
                CH_SEMI: begin
                    s_emit = 1'b1;
                    s_kind = KIND_TERMINAL;
                    s_len  = POSITION_WIDTH'(1);
                end
                CH_LBRC: begin
                    s_emit = 1'b1;
                    s_kind = KIND_OPEN;
                    s_len  = POSITION_WIDTH'(1);
                end
                CH_RBRC: begin
                    s_emit = 1'b1;
                    s_kind = KIND_CLOSE;
                    s_len  = POSITION_WIDTH'(1);
                end
                CH_EQ: begin
                    s_emit = 1'b1;
                    s_kind = KIND_ASSIGN;
                    s_len  = POSITION_WIDTH'(1);
                end
                CH_SLASH: begin
                    n_start = eff_pos;
                    n_mode  = MODE_SLASH;
                end
                CH_QUOTE: begin
                    n_start = eff_pos;
                    n_mode  = MODE_STRING;
                end
                default: begin
                    if (i_byte == CH_MINUS || is_digit) begin
                        n_start = eff_pos;
                        n_dot   = 1'b0;
                        n_mode  = MODE_NUMBER;
                    end else if (is_letter || i_byte == CH_UNDER) begin
                        n_start = eff_pos;
                        n_mode  = MODE_IDENT;
                    end else begin
                        s_emit = 1'b1;
                        s_kind = KIND_ERROR;
                        s_code = ERR_BAD_CHAR;
                        n_mode = MODE_HALT;
                    end
                end
            endcase
        end

        n_line = (line_inc && eff_line != '1) ? eff_line + LINE_WIDTH'(1) : eff_line;
    end

    always_comb begin
        tok_p.kind   = p_kind;
        tok_p.code   = p_code;
        tok_p.start  = sat_pos(p_start);
        tok_p.length = sat_pos(p_len);
        tok_p.line   = sat_line(eff_line);
        tok_p.last   = !s_emit;

        tok_s.kind   = s_kind;
        tok_s.code   = s_code;
        tok_s.start  = sat_pos(eff_pos);
        tok_s.length = sat_pos(s_len);
        tok_s.line   = sat_line(eff_line);
        tok_s.last   = 1'b1;

        o_lex.first  = p_emit ? tok_p : tok_s;
        o_lex.second = tok_s;
        o_lex.count  = (i_fire && active) ? (2'(p_emit) + 2'(s_emit)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_dot   <= 1'b0;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= LINE_WIDTH'(1);
        end else if (i_fire && active) begin
            r_mode  <= n_mode;
            r_dot   <= n_dot;
            r_start <= n_start;
            r_pos   <= pos_inc;
            r_line  <= n_line;
        end
    end

`ifndef NO_ASSERTIONS
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line count reached zero");

    a_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start <= r_pos)
        else $error("token start beyond byte position");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_mode == MODE_HALT && !i_restart) |-> (o_lex.count == 2'd0))
        else $error("result while halted");

    a_pair_closes_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lex.count == 2'd2) |-> (o_lex.first.kind == KIND_NUMBER ||
                                   o_lex.first.kind == KIND_IDENT ||
                                   o_lex.first.kind == KIND_COMMENT))
        else $error("two results without a closed pending token");
`endif
endmodule
`default_nettype wire

@@ design/ett_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ett_out_queue: small result queue that takes up to two tokens per cycle
// and delivers one per transaction. Depends on ett_pkg and ett_out_if.
module ett_out_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ett_pkg::t_lex_out i_lex,
    output logic                   o_room,
    ett_out_if.source              o_out
);
    import ett_pkg::*;

    t_token              r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                pop;
    t_token              head;

    assign pop    = o_out.valid && o_out.ready;
    assign o_room = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head   = r_mem[r_rd_ptr];

    assign o_out.valid        = (r_count != '0);
    assign o_out.token_kind   = head.kind;
    assign o_out.error_code   = head.code;
    assign o_out.token_start  = head.start;
    assign o_out.token_length = head.length;
    assign o_out.line_number  = head.line;
    assign o_out.last_of_run  = head.last;

    always_ff @(posedge i_clk) begin
        if (i_lex.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_lex.first;
        end
        if (i_lex.count == 2'd2) begin
            r_mem[r_wr_ptr + QP_W'(1)] <= i_lex.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QP_W'(i_lex.count);
            r_rd_ptr <= r_rd_ptr + QP_W'(pop);
            r_count  <= r_count + QCNT_W'(i_lex.count) - QCNT_W'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lex.count != 2'd0) |-> o_room)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lex.count == 2'd0 && !pop) |=> (r_count == $past(r_count)))
        else $error("queue count moved without traffic");
`endif
endmodule
`default_nettype wire

@@ design/entity_text_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// entity_text_tokenizer: streaming text tokenizer top level.
// Depends on ett_pkg, ett_if, ett_lex_core and ett_out_queue.
//
//   channel  | dir | payload                                           | results
//   ---------+-----+---------------------------------------------------+--------
//   i_in     | in  | text_byte, restart                                | -
//   o_out    | out | token_kind, error_code, token_start, token_length,| 0..2
//            |     | line_number, last_of_run                          | / byte
//
// One text byte is lexed per cycle while the queue has room. A taken byte is
// held in the input register until it is lexed, and its results are written
// into the queue, from which they can leave. Each byte leaves zero, one or
// two results; the output port moves one per transaction, so bytes that close
// a pending token and are themselves a token need two output transactions.
// The input holds off only when the four-entry result queue lacks room for
// two more tokens. Reset is synchronous, active low: it empties the queue and
// the input register and puts the lexer to idle at offset zero on line one.
module entity_text_tokenizer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ett_in_if.sink    i_in,
    ett_out_if.source o_out
);
    import ett_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_restart;
    logic       fire;
    logic       room;
    t_lex_out   lex;

    // Lex the registered byte once the queue can hold both possible results
    assign fire       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || fire;

    // Input register: refill in the same cycle the held byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload needs no reset; load on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte    <= i_in.text_byte;
            r_restart <= i_in.restart;
        end
    end

    ett_lex_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_byte),
        .i_restart (r_restart),
        .o_lex     (lex)
    );

    ett_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lex   (lex),
        .o_room  (room),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    a_fire_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> r_in_valid)
        else $error("lex step without a held byte");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !room) |-> !i_in.ready)
        else $error("input taken while queue is full");

    a_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_in_valid) && !$past(fire)) |-> ($stable(r_byte) && r_in_valid))
        else $error("held byte lost before lexing");
`endif
endmodule
`default_nettype wire
